@@ hw/rtl/srpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package srpc_pkg;

    localparam int unsigned CHANNELS = 3;

    typedef logic [7:0] byte_t;

    typedef enum logic [1:0] {
        SEL_NONE  = 2'd0,
        SEL_RED   = 2'd1,
        SEL_GREEN = 2'd2,
        SEL_BLUE  = 2'd3
    } sel_t;

    localparam byte_t CHAR_R    = 8'h72;
    localparam byte_t CHAR_G    = 8'h67;
    localparam byte_t CHAR_B    = 8'h62;
    localparam byte_t CHAR_F    = 8'h66;
    localparam byte_t CHAR_0    = 8'h30;
    localparam byte_t CHAR_9    = 8'h39;
    localparam byte_t LEVEL_MAX = 8'hFF;

    localparam logic ACTION_BYTE = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

endpackage

`default_nettype wire

@@ hw/rtl/serial_rgb_pwm_command.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Serial-commanded RGB PWM. Each request is either a received byte (action 0) or one
// PWM counter tick (action 1), and every request gives one result: the three pin levels
// and the three commanded brightness levels after the request is applied. 'r', 'g', 'b'
// select a channel, DIGIT_COUNT decimal digits then set its level, 'f' turns all levels
// off; pending levels take effect when the shared 8-bit counter wraps. One request is
// taken every cycle and its result appears in the next cycle from the output register;
// the single stage of next-state logic and that register set the rate, and a request
// waits only while a finished result is held by a stalled receiver.
module serial_rgb_pwm_command #(
    parameter int unsigned DIGIT_COUNT = 3
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_stall,
    input  wire logic              action,
    input  wire srpc_pkg::byte_t   rx_byte,
    output logic                   pwm_valid,
    input  wire logic              pwm_stall,
    output logic                   red_pin,
    output logic                   green_pin,
    output logic                   blue_pin,
    output srpc_pkg::byte_t        red_brightness,
    output srpc_pkg::byte_t        green_brightness,
    output srpc_pkg::byte_t        blue_brightness
);

    import srpc_pkg::*;

    localparam logic [1:0] DIGIT_LAST = DIGIT_COUNT[1:0];

    byte_t       cnt_reg, cnt_next;
    byte_t       pend_reg [CHANNELS];
    byte_t       pend_next [CHANNELS];
    byte_t       act_reg [CHANNELS];
    byte_t       act_next [CHANNELS];
    sel_t        sel_reg, sel_next;
    logic [1:0]  digits_reg, digits_next;
    byte_t       sum_reg, sum_next;
    logic        valid_reg;
    logic [2:0]  pin_reg, pin_next;
    byte_t       bright_reg [CHANNELS];

    logic        accept;
    logic        is_digit;
    byte_t       digit;
    byte_t       sum_step;
    logic [1:0]  digits_step;
    logic [1:0]  chan_idx;

    assign cmd_stall = valid_reg & pwm_stall;
    assign accept    = cmd_valid & ~cmd_stall;

    assign is_digit    = (rx_byte >= CHAR_0) && (rx_byte <= CHAR_9);
    assign digit       = rx_byte - CHAR_0;
    assign sum_step    = {sum_reg[4:0], 3'b000} + {sum_reg[6:0], 1'b0} + digit;
    assign digits_step = digits_reg + 2'd1;
    assign chan_idx    = sel_reg - 2'd1;

    always_comb
    begin
        cnt_next    = cnt_reg;
        sel_next    = sel_reg;
        digits_next = digits_reg;
        sum_next    = sum_reg;
        for (int i = 0; i < CHANNELS; i++)
        begin
            pend_next[i] = pend_reg[i];
            act_next[i]  = act_reg[i];
        end

        if (action == ACTION_TICK)
        begin
            cnt_next = cnt_reg + 8'd1;
            if (cnt_reg == LEVEL_MAX)
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    act_next[i] = pend_reg[i];
                end
            end
        end
        else
        begin
            if (is_digit && sel_reg != SEL_NONE)
            begin
                if (digits_step >= DIGIT_LAST)
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        if (chan_idx == i[1:0])
                        begin
                            pend_next[i] = ~sum_step;
                        end
                    end
                    sel_next    = SEL_NONE;
                    digits_next = 2'd0;
                    sum_next    = 8'd0;
                end
                else
                begin
                    digits_next = digits_step;
                    sum_next    = sum_step;
                end
            end
            case (rx_byte)
                CHAR_R: sel_next = SEL_RED;
                CHAR_G: sel_next = SEL_GREEN;
                CHAR_B: sel_next = SEL_BLUE;
                CHAR_F:
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        pend_next[i] = LEVEL_MAX;
                    end
                end
                default: ;
            endcase
        end

        for (int i = 0; i < CHANNELS; i++)
        begin
            pin_next[i] = cnt_next > act_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            sel_reg    <= SEL_NONE;
            digits_reg <= '0;
            sum_reg    <= '0;
            valid_reg  <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                pend_reg[i] <= LEVEL_MAX;
                act_reg[i]  <= LEVEL_MAX;
            end
        end
        else
        begin
            if (accept)
            begin
                cnt_reg    <= cnt_next;
                sel_reg    <= sel_next;
                digits_reg <= digits_next;
                sum_reg    <= sum_next;
                for (int i = 0; i < CHANNELS; i++)
                begin
                    pend_reg[i] <= pend_next[i];
                    act_reg[i]  <= act_next[i];
                end
                valid_reg <= 1'b1;
            end
            else if (!pwm_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pin_reg <= pin_next;
            for (int i = 0; i < CHANNELS; i++)
            begin
                bright_reg[i] <= ~pend_next[i];
            end
        end
    end

    assign pwm_valid        = valid_reg;
    assign red_pin          = pin_reg[0];
    assign green_pin        = pin_reg[1];
    assign blue_pin         = pin_reg[2];
    assign red_brightness   = bright_reg[0];
    assign green_brightness = bright_reg[1];
    assign blue_brightness  = bright_reg[2];

    a_digits_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        digits_reg < DIGIT_LAST)
        else $error("digit count reached the number length");

    a_sum_clear_with_count: assert property (@(posedge clk) disable iff (!rst_n)
        (digits_reg == 2'd0) |-> (sum_reg == 8'd0))
        else $error("partial value left without digits");

    a_counter_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && action == ACTION_TICK) |=> $stable(cnt_reg))
        else $error("counter moved without a tick");

    a_wrap_loads_active: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action == ACTION_TICK && cnt_reg == LEVEL_MAX)
        |=> (act_reg[0] == $past(pend_reg[0]) && act_reg[1] == $past(pend_reg[1])
             && act_reg[2] == $past(pend_reg[2])))
        else $error("active compares not loaded on wrap");

    a_brightness_tracks_pending: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (red_brightness == ~pend_reg[0] && green_brightness == ~pend_reg[1]
                    && blue_brightness == ~pend_reg[2]))
        else $error("brightness does not match pending compare");

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import srpc_pkg::*;

    localparam int NUM_DIGITS = 3;
    localparam int RESET_CYCLES = 6;
    localparam int LONG_HOLD = 300;
    localparam int IDLE_LIMIT = 5000;
    localparam int TOTAL_REQUESTS = 1800;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {
        REQ_ITEM,
        REQ_HOLD,
        REQ_DRAIN
    } req_kind_t;

    typedef enum logic [1:0] {
        PACE_NONSTOP,
        PACE_SPARSE,
        PACE_LIGHT
    } pace_t;

    typedef struct packed {
        req_kind_t kind;
        logic      act;
        byte_t     data;
    } request_t;

    typedef struct packed {
        logic  red_on;
        logic  green_on;
        logic  blue_on;
        byte_t red_level;
        byte_t green_level;
        byte_t blue_level;
    } pwm_result_t;

    logic  clk;
    logic  rst_n;
    logic  cmd_valid;
    logic  cmd_stall;
    logic  action;
    byte_t rx_byte;
    logic  pwm_valid;
    logic  pwm_stall;
    logic  red_pin;
    logic  green_pin;
    logic  blue_pin;
    byte_t red_brightness;
    byte_t green_brightness;
    byte_t blue_brightness;

    byte_t tick_count;
    byte_t pending_cmp [CHANNELS];
    byte_t active_cmp [CHANNELS];
    sel_t  channel_sel;
    int    digit_cnt;
    byte_t digit_acc;

    request_t    request_q [$];
    pwm_result_t expected_pwm [$];

    request_t    head;
    pwm_result_t want_res;
    logic        next_valid;
    bit          request_taken;
    bit          result_taken;
    bit          hold_asked;
    bit          hold_placed;
    bit          drain_placed;
    pace_t       send_pace;
    pace_t       recv_pace;
    int          send_wait;
    int          recv_wait;
    int          hold_left;
    int          idle_cycles;
    int          queued;
    int          mismatches;

    serial_rgb_pwm_command #(
        .DIGIT_COUNT(NUM_DIGITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .action(action),
        .rx_byte(rx_byte),
        .pwm_valid(pwm_valid),
        .pwm_stall(pwm_stall),
        .red_pin(red_pin),
        .green_pin(green_pin),
        .blue_pin(blue_pin),
        .red_brightness(red_brightness),
        .green_brightness(green_brightness),
        .blue_brightness(blue_brightness)
    );

    always #5 clk = ~clk;

    function pwm_result_t apply_request(input logic act, input byte_t b);
        pwm_result_t res;
        int ch;
        if (act == ACTION_TICK)
        begin
            tick_count = tick_count + 8'd1;
            if (tick_count == 8'd0)
            begin
                for (ch = 0; ch < CHANNELS; ch++)
                    active_cmp[ch] = pending_cmp[ch];
            end
        end
        else
        begin
            if (b >= CHAR_0 && b <= CHAR_9 && channel_sel != SEL_NONE)
            begin
                digit_acc = digit_acc * 8'd10 + (b - CHAR_0);
                digit_cnt++;
                if (digit_cnt >= NUM_DIGITS)
                begin
                    pending_cmp[int'(channel_sel) - 1] = LEVEL_MAX - digit_acc;
                    channel_sel = SEL_NONE;
                    digit_cnt = 0;
                    digit_acc = 8'd0;
                end
            end
            if (b == CHAR_R)
                channel_sel = SEL_RED;
            if (b == CHAR_G)
                channel_sel = SEL_GREEN;
            if (b == CHAR_B)
                channel_sel = SEL_BLUE;
            if (b == CHAR_F)
            begin
                for (ch = 0; ch < CHANNELS; ch++)
                    pending_cmp[ch] = LEVEL_MAX;
            end
        end
        res.red_on = tick_count > active_cmp[0];
        res.green_on = tick_count > active_cmp[1];
        res.blue_on = tick_count > active_cmp[2];
        res.red_level = LEVEL_MAX - pending_cmp[0];
        res.green_level = LEVEL_MAX - pending_cmp[1];
        res.blue_level = LEVEL_MAX - pending_cmp[2];
        return res;
    endfunction

    function automatic int draw_wait(input pace_t pace);
        case (pace)
            PACE_NONSTOP: return 0;
            PACE_SPARSE: return $urandom_range(0, 18);
            default: return $urandom_range(0, 2);
        endcase
    endfunction

    function automatic byte_t pick_channel();
        case ($urandom_range(0, 2))
            0: return CHAR_R;
            1: return CHAR_G;
            default: return CHAR_B;
        endcase
    endfunction

    task automatic queue_request(input req_kind_t kind, input logic act, input byte_t data);
        request_t req;
        req.kind = kind;
        req.act = act;
        req.data = data;
        request_q.push_back(req);
        if (kind == REQ_ITEM)
            queued++;
    endtask

    task automatic push_byte(input byte_t b);
        queue_request(REQ_ITEM, ACTION_BYTE, b);
    endtask

    task automatic push_digit(input int d);
        push_byte(CHAR_0 + byte_t'(d));
    endtask

    task automatic push_ticks(input int n);
        repeat (n)
            queue_request(REQ_ITEM, ACTION_TICK, byte_t'($urandom_range(0, 255)));
    endtask

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
            report($sformatf("%s expected %0d got %0d", name, want, got));
    endtask

    // predict on every accepted request
    always @(posedge clk)
    begin
        if (rst_n && cmd_valid && !cmd_stall)
        begin
            request_taken = 1'b1;
            expected_pwm.push_back(apply_request(action, rx_byte));
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && !(cmd_valid && !request_taken))
        begin
            next_valid = 1'b0;
            if (send_wait > 0)
                send_wait--;
            else if (request_q.size() > 0 &&
                     (request_q[0].kind != REQ_DRAIN || expected_pwm.size() == 0))
            begin
                head = request_q.pop_front();
                case (head.kind)
                    REQ_HOLD:
                    begin
                        hold_asked = 1'b1;
                        send_pace = PACE_NONSTOP;
                    end
                    REQ_DRAIN: ;
                    default:
                    begin
                        action <= head.act;
                        rx_byte <= head.data;
                        next_valid = 1'b1;
                        if ($urandom_range(0, 39) == 0)
                            send_pace = pace_t'($urandom_range(0, 2));
                        send_wait = draw_wait(send_pace);
                    end
                endcase
            end
            cmd_valid <= next_valid;
            request_taken = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pwm_valid && !pwm_stall)
        begin
            result_taken = 1'b1;
            if (expected_pwm.size() == 0)
                report("result with no request outstanding");
            else
            begin
                want_res = expected_pwm.pop_front();
                check_field("red_pin", {7'd0, want_res.red_on}, {7'd0, red_pin});
                check_field("green_pin", {7'd0, want_res.green_on}, {7'd0, green_pin});
                check_field("blue_pin", {7'd0, want_res.blue_on}, {7'd0, blue_pin});
                check_field("red_brightness", want_res.red_level, red_brightness);
                check_field("green_brightness", want_res.green_level, green_brightness);
                check_field("blue_brightness", want_res.blue_level, blue_brightness);
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_asked)
            begin
                hold_left = LONG_HOLD;
                hold_asked = 1'b0;
            end
            if (result_taken)
            begin
                result_taken = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    recv_pace = pace_t'($urandom_range(0, 2));
                recv_wait = draw_wait(recv_pace);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pwm_stall <= 1'b1;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                pwm_stall <= 1'b1;
            end
            else
                pwm_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (pwm_valid && !pwm_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        action = 1'b0;
        rx_byte = 8'd0;
        pwm_stall = 1'b0;
        tick_count = 8'd0;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            pending_cmp[ch] = LEVEL_MAX;
            active_cmp[ch] = LEVEL_MAX;
        end
        channel_sel = SEL_NONE;
        digit_cnt = 0;
        digit_acc = 8'd0;
        send_pace = PACE_NONSTOP;
        recv_pace = PACE_NONSTOP;

        push_digit(9);
        queue_request(REQ_ITEM, ACTION_TICK, 8'hFF);
        push_byte(CHAR_R);
        push_digit(2);
        push_digit(5);
        push_digit(5);
        push_byte(CHAR_G);
        push_digit(0);
        push_digit(0);
        push_digit(0);
        push_byte(CHAR_B);
        push_digit(9);
        push_digit(9);
        push_digit(9);
        push_byte(CHAR_R);
        push_digit(1);
        push_byte(CHAR_G);
        push_digit(2);
        push_digit(3);
        push_byte(CHAR_R);
        push_digit(4);
        push_byte(CHAR_F);
        push_digit(5);
        push_digit(6);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(CHAR_0 - 8'd1);
        push_byte(CHAR_9 + 8'd1);

        while (queued < TOTAL_REQUESTS)
        begin
            if (!hold_placed && queued > TOTAL_REQUESTS / 3)
            begin
                queue_request(REQ_HOLD, 1'b0, 8'd0);
                hold_placed = 1'b1;
            end
            if (!drain_placed && queued > 2 * TOTAL_REQUESTS / 3)
            begin
                queue_request(REQ_DRAIN, 1'b0, 8'd0);
                drain_placed = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    push_byte(pick_channel());
                    repeat (NUM_DIGITS)
                        push_digit($urandom_range(0, 9));
                end
                4, 5: push_ticks($urandom_range(1, 120));
                6: push_byte(CHAR_F);
                7:
                begin
                    push_byte(pick_channel());
                    repeat ($urandom_range(1, NUM_DIGITS - 1))
                        push_digit($urandom_range(0, 9));
                end
                8: push_byte(byte_t'($urandom_range(0, 255)));
                default: push_digit($urandom_range(0, 9));
            endcase
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (request_q.size() > 0 || cmd_valid)
            @(posedge clk);
        while (expected_pwm.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_pwm.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
